// ===== design/wsfr_pkg.sv =====
// Types, codes and constants shared by the fragment reassembly checker.
package wsfr_pkg;

    localparam int unsigned LEN_W       = 17;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD = LEN_W'(65536);

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    localparam logic [3:0] OPC_CONT   = 4'h0;
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_PONG   = 4'hA;

    typedef enum logic [3:0] {
        ST_PARTIAL    = 4'd0,
        ST_COMPLETE   = 4'd1,
        ST_FULL_NOFIN = 4'd2,
        ST_EMPTY      = 4'd3,
        ST_CONTROL    = 4'd4,
        ST_BOUNDARY   = 4'd5,
        ST_OPCODE     = 4'd6,
        ST_FIRST_OP   = 4'd7,
        ST_NO_BUFFER  = 4'd8,
        ST_SEQUENCE   = 4'd9,
        ST_BINARY     = 4'd10,
        ST_EARLY_FIN  = 4'd11,
        ST_RESET      = 4'd12
    } status_t;

    typedef struct packed {
        logic             operation;
        logic [LEN_W-1:0] total_length;
        logic [LEN_W-1:0] chunk_offset;
        logic [LEN_W-1:0] chunk_length;
        logic [3:0]       frame_opcode;
        logic             final_flag;
        logic             buffer_free;
    } chunk_item_t;

    typedef struct packed {
        status_t          status;
        logic             write_enable;
        logic [LEN_W-1:0] write_offset;
        logic [LEN_W-1:0] write_length;
        logic             claim_buffer;
        logic             release_buffer;
        logic             message_done;
        logic [LEN_W-1:0] message_length;
    } chunk_result_t;

    typedef struct packed {
        logic [LEN_W-1:0] expected_length;
        logic [LEN_W-1:0] received_length;
        logic             assembling;
        logic             text_message;
        logic             holding_buffer;
    } asm_state_t;

endpackage

// ===== design/ws_fragment_reassembly_checker_core.sv =====
// Top level of the WebSocket fragment reassembly checker.
// Inputs are held in in_item_reg, results in out_res_reg on the master side.
// Throughput: one chunk descriptor per cycle while m_axis_tready stays high.
// A stalled result holds the result register; one more input transfer fills the
// input register, then s_axis_tready drops until m_axis_tready returns.
// Reset: rst_n clears the assembly state and both valid flags at once.
module ws_fragment_reassembly_checker_core
    import wsfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // total_length[16:0], chunk_offset[33:17], chunk_length[50:34],
    // frame_opcode[54:51], buffer_free[55]
    input  logic [55:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // final_flag
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[3:0], write_enable[4], write_offset[21:5], write_length[38:22],
    // claim_buffer[39], release_buffer[40], message_done[41],
    // message_length[58:42], zero[63:59]
    output logic [63:0] m_axis_tdata
);

    logic          in_valid_reg;
    logic          in_valid_next;
    chunk_item_t   in_item_reg;
    chunk_item_t   in_item_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    chunk_result_t out_res_reg;
    chunk_result_t out_res_next;
    chunk_result_t eng_result;
    logic          advance;
    logic          in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_item_next.operation    = s_axis_tuser;
        in_item_next.total_length = s_axis_tdata[16:0];
        in_item_next.chunk_offset = s_axis_tdata[33:17];
        in_item_next.chunk_length = s_axis_tdata[50:34];
        in_item_next.frame_opcode = s_axis_tdata[54:51];
        in_item_next.buffer_free  = s_axis_tdata[55];
        in_item_next.final_flag   = s_axis_tlast;
        in_valid_next  = in_take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_axis_tready);
        out_res_next   = eng_result;
    end

    wsfr_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (eng_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item_next;
        end
        if (advance)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0,
                            out_res_reg.message_length,
                            out_res_reg.message_done,
                            out_res_reg.release_buffer,
                            out_res_reg.claim_buffer,
                            out_res_reg.write_length,
                            out_res_reg.write_offset,
                            out_res_reg.write_enable,
                            out_res_reg.status};

endmodule

// ===== design/wsfr_engine.sv =====
// Assembly state registers and the per-chunk check and update logic.
module wsfr_engine
    import wsfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  chunk_item_t   item,
    output chunk_result_t result
);

    asm_state_t state_reg;
    asm_state_t state_next;

    always_comb
    begin
        logic             go;
        logic [LEN_W-1:0] rcv;
        state_next = state_reg;
        result     = '0;
        result.status = ST_PARTIAL;
        go  = 1'b0;
        rcv = LEN_W'(item.chunk_offset + item.chunk_length);
        priority if (item.operation == OP_RESET)
        begin
            result.release_buffer = state_next.holding_buffer;
            state_next = '0;
            result.status = ST_RESET;
        end
        else if (item.chunk_length == '0 || item.total_length == '0)
        begin
            result.status = ST_EMPTY;
        end
        else if (item.total_length > MAX_PAYLOAD
                 || item.chunk_offset > item.total_length
                 || item.chunk_length > LEN_W'(item.total_length - item.chunk_offset))
        begin
            result.release_buffer = state_next.holding_buffer;
            state_next = '0;
            result.status = ST_BOUNDARY;
        end
        else if (item.frame_opcode == OPC_CLOSE || item.frame_opcode == OPC_PING
                 || item.frame_opcode == OPC_PONG)
        begin
            result.status = ST_CONTROL;
        end
        else if (item.frame_opcode > OPC_BINARY)
        begin
            result.release_buffer = state_next.holding_buffer;
            state_next = '0;
            result.status = ST_OPCODE;
        end
        else
        begin
            go = 1'b1;
            if (item.chunk_offset == '0)
            begin
                result.release_buffer = state_next.holding_buffer;
                state_next = '0;
                priority if (item.frame_opcode == OPC_CONT)
                begin
                    result.status = ST_FIRST_OP;
                    go = 1'b0;
                end
                else if (!item.buffer_free)
                begin
                    result.status = ST_NO_BUFFER;
                    go = 1'b0;
                end
                else
                begin
                    result.claim_buffer        = 1'b1;
                    state_next.holding_buffer  = 1'b1;
                    state_next.expected_length = item.total_length;
                    state_next.received_length = '0;
                    state_next.assembling      = 1'b1;
                    state_next.text_message    = (item.frame_opcode == OPC_TEXT);
                end
            end
            else if (!state_reg.assembling
                     || state_reg.expected_length != item.total_length
                     || item.chunk_offset != state_reg.received_length
                     || item.frame_opcode != OPC_CONT)
            begin
                result.release_buffer = state_next.holding_buffer;
                state_next = '0;
                result.status = ST_SEQUENCE;
                go = 1'b0;
            end
            if (go && !state_next.text_message)
            begin
                result.release_buffer = result.release_buffer | state_next.holding_buffer;
                state_next = '0;
                result.status = ST_BINARY;
                go = 1'b0;
            end
            if (go)
            begin
                result.write_enable = 1'b1;
                result.write_offset = item.chunk_offset;
                result.write_length = item.chunk_length;
                state_next.received_length = rcv;
                priority if (item.final_flag && rcv != state_next.expected_length)
                begin
                    result.release_buffer = result.release_buffer
                                            | state_next.holding_buffer;
                    state_next = '0;
                    result.status = ST_EARLY_FIN;
                end
                else if (!item.final_flag && rcv == state_next.expected_length)
                begin
                    result.status = ST_FULL_NOFIN;
                end
                else if (rcv != state_next.expected_length)
                begin
                    result.status = ST_PARTIAL;
                end
                else
                begin
                    result.message_done   = 1'b1;
                    result.message_length = state_next.expected_length;
                    state_next = '0;
                    result.status = ST_COMPLETE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== bench/tb_ws_fragment_reassembly_checker_core.sv =====
// Stream testbench for the fragment reassembly checker: directed and random chunk traffic.
module tb_ws_fragment_reassembly_checker_core;
    timeunit 1ns;
    timeprecision 1ps;
    import wsfr_pkg::*;

    localparam int IDLE_PCT       = 19;
    localparam int RANDOM_CHUNKS  = 1000;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int MAX_REPORTS    = 10;
    localparam int STEADY_FROM    = 400;
    localparam int STEADY_TO      = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    chunk_item_t   pending_chunks[$];
    chunk_result_t expected_results[$];
    chunk_item_t   live_chunk;
    asm_state_t    asm_model;

    int cycle_count = 0;
    int quiet_cycles = 0;
    int chunks_sent = 0;
    int results_seen = 0;
    int messages_done = 0;
    int errors = 0;
    int status_hits[16];

    ws_fragment_reassembly_checker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit take_break();
        if (cycle_count >= STEADY_FROM && cycle_count < STEADY_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    function automatic logic drop_assembly();
        logic held;
        held = asm_model.holding_buffer;
        asm_model = '0;
        return held;
    endfunction

    function automatic chunk_result_t judge_chunk(chunk_item_t c);
        chunk_result_t    r;
        logic             go;
        logic [LEN_W-1:0] reach;
        r = '0;
        r.status = ST_PARTIAL;
        go = 1'b0;
        if (c.operation == OP_RESET)
        begin
            r.release_buffer = drop_assembly();
            r.status = ST_RESET;
        end
        else if (c.chunk_length == '0 || c.total_length == '0)
            r.status = ST_EMPTY;
        else if (c.total_length > MAX_PAYLOAD || c.chunk_offset > c.total_length ||
                 c.chunk_length > c.total_length - c.chunk_offset)
        begin
            r.release_buffer = drop_assembly();
            r.status = ST_BOUNDARY;
        end
        else if (c.frame_opcode == OPC_CLOSE || c.frame_opcode == OPC_PING ||
                 c.frame_opcode == OPC_PONG)
            r.status = ST_CONTROL;
        else if (c.frame_opcode > OPC_BINARY)
        begin
            r.release_buffer = drop_assembly();
            r.status = ST_OPCODE;
        end
        else if (c.chunk_offset == '0)
        begin
            r.release_buffer = drop_assembly();
            if (c.frame_opcode == OPC_CONT)
                r.status = ST_FIRST_OP;
            else if (!c.buffer_free)
                r.status = ST_NO_BUFFER;
            else
            begin
                r.claim_buffer = 1'b1;
                asm_model.holding_buffer = 1'b1;
                asm_model.expected_length = c.total_length;
                asm_model.received_length = '0;
                asm_model.assembling = 1'b1;
                asm_model.text_message = (c.frame_opcode == OPC_TEXT);
                go = 1'b1;
            end
        end
        else if (!asm_model.assembling || asm_model.expected_length != c.total_length ||
                 c.chunk_offset != asm_model.received_length || c.frame_opcode != OPC_CONT)
        begin
            r.release_buffer = drop_assembly();
            r.status = ST_SEQUENCE;
        end
        else
            go = 1'b1;

        if (go && !asm_model.text_message)
        begin
            r.release_buffer |= drop_assembly();
            r.status = ST_BINARY;
            go = 1'b0;
        end

        if (go)
        begin
            r.write_enable = 1'b1;
            r.write_offset = c.chunk_offset;
            r.write_length = c.chunk_length;
            reach = c.chunk_offset + c.chunk_length;
            asm_model.received_length = reach;
            if (c.final_flag && reach != asm_model.expected_length)
            begin
                r.release_buffer |= drop_assembly();
                r.status = ST_EARLY_FIN;
            end
            else if (!c.final_flag && reach == asm_model.expected_length)
                r.status = ST_FULL_NOFIN;
            else if (reach != asm_model.expected_length)
                r.status = ST_PARTIAL;
            else
            begin
                r.message_done = 1'b1;
                r.message_length = asm_model.expected_length;
                asm_model = '0;
                r.status = ST_COMPLETE;
            end
        end
        return r;
    endfunction

    function automatic void add_chunk(logic op, int total, int off, int len,
                                      logic [3:0] opc, logic fin, logic freebuf);
        chunk_item_t c;
        c.operation = op;
        c.total_length = LEN_W'(total);
        c.chunk_offset = LEN_W'(off);
        c.chunk_length = LEN_W'(len);
        c.frame_opcode = opc;
        c.final_flag = fin;
        c.buffer_free = freebuf;
        pending_chunks.push_back(c);
    endfunction

    // Well-formed message split into chunks, with at most one flaw.
    function automatic void add_message();
        int         total;
        int         pieces;
        int         off;
        int         len;
        int         flaw;
        int         flaw_at;
        int         pick;
        logic [3:0] opc;
        logic [3:0] first_opc;
        logic       fin;
        logic       freebuf;
        pick = $urandom_range(0, 99);
        total = (pick < 70) ? $urandom_range(1, 48) :
                (pick < 95) ? $urandom_range(1, 65536) : 65536;
        pieces = $urandom_range(1, 4);
        if (pieces > total)
            pieces = total;
        first_opc = ($urandom_range(0, 99) < 88) ? OPC_TEXT : OPC_BINARY;
        freebuf = ($urandom_range(0, 99) < 93);
        flaw = ($urandom_range(0, 99) < 35) ? $urandom_range(1, 8) : 0;
        flaw_at = $urandom_range(0, pieces - 1);
        off = 0;
        for (int k = 0; k < pieces; k++)
        begin
            if (k == pieces - 1)
                len = total - off;
            else
                len = $urandom_range(1, total - off - (pieces - 1 - k));
            opc = (k == 0) ? first_opc : OPC_CONT;
            fin = (k == pieces - 1);
            if (flaw != 0 && k == flaw_at)
            begin
                case (flaw)
                    1: add_chunk(OP_DATA, total, off, len,
                                 4'(OPC_CLOSE + $urandom_range(0, 2)), fin, freebuf);
                    2: fin = ~fin;
                    3: off = off + 1;
                    4: total = total + $urandom_range(1, 3);
                    5: opc = (k == 0) ? OPC_CONT : OPC_TEXT;
                    6: add_chunk(OP_DATA, total, off, 0, opc, fin, freebuf);
                    7: add_chunk(OP_RESET, total, off, len, opc, fin, freebuf);
                    default:
                    begin
                        if (k > 0)
                            return;
                        opc = 4'($urandom_range(3, 7));
                    end
                endcase
            end
            add_chunk(OP_DATA, total, off, len, opc, fin,
                      (k == 0) ? freebuf : logic'($urandom_range(0, 1)));
            off = off + len;
        end
    endfunction

    function automatic void add_noise();
        int total;
        int off;
        int len;
        total = $urandom_range(0, 1) ? $urandom_range(0, 131071) : $urandom_range(0, 70);
        off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, total);
        if ($urandom_range(0, 3) == 0)
            len = $urandom_range(0, 131071);
        else if (off <= total)
            len = $urandom_range(0, total - off + 1);
        else
            len = $urandom_range(0, 100);
        add_chunk(($urandom_range(0, 99) < 8) ? OP_RESET : OP_DATA, total, off, len,
                  4'($urandom_range(0, 15)), logic'($urandom_range(0, 1)),
                  logic'($urandom_range(0, 1)));
    endfunction

    // Sender: present queued chunks, predict each one as it transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            s_axis_tuser <= 1'b0;
            asm_model = '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(judge_chunk(live_chunk));
                chunks_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_chunks.size() > 0 && !take_break())
                begin
                    live_chunk = pending_chunks.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {live_chunk.buffer_free, live_chunk.frame_opcode,
                                     live_chunk.chunk_length, live_chunk.chunk_offset,
                                     live_chunk.total_length};
                    s_axis_tlast <= live_chunk.final_flag;
                    s_axis_tuser <= live_chunk.operation;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, check each result transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        chunk_result_t got;
        chunk_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = status_t'(m_axis_tdata[3:0]);
                got.write_enable = m_axis_tdata[4];
                got.write_offset = m_axis_tdata[21:5];
                got.write_length = m_axis_tdata[38:22];
                got.claim_buffer = m_axis_tdata[39];
                got.release_buffer = m_axis_tdata[40];
                got.message_done = m_axis_tdata[41];
                got.message_length = m_axis_tdata[58:42];
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result transfer, data %h", m_axis_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    status_hits[want.status]++;
                    if (want.message_done)
                        messages_done++;
                    if (got.status !== want.status ||
                        got.write_enable !== want.write_enable ||
                        got.write_offset !== want.write_offset ||
                        got.write_length !== want.write_length ||
                        got.claim_buffer !== want.claim_buffer ||
                        got.release_buffer !== want.release_buffer ||
                        got.message_done !== want.message_done ||
                        got.message_length !== want.message_length)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("result %0d exp: st=%0d we=%0b wo=%0d wl=%0d cl=%0b rl=%0b dn=%0b ml=%0d",
                                     results_seen, want.status, want.write_enable,
                                     want.write_offset, want.write_length, want.claim_buffer,
                                     want.release_buffer, want.message_done,
                                     want.message_length);
                            $display("result %0d got: st=%0d we=%0b wo=%0d wl=%0d cl=%0b rl=%0b dn=%0b ml=%0d",
                                     results_seen, got.status, got.write_enable,
                                     got.write_offset, got.write_length, got.claim_buffer,
                                     got.release_buffer, got.message_done,
                                     got.message_length);
                        end
                    end
                end
            end
            m_axis_tready <= !take_break();
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int directed_count;
        foreach (status_hits[i])
            status_hits[i] = 0;

        add_chunk(OP_RESET, 0, 0, 0, OPC_CONT, 1'b0, 1'b0);
        add_chunk(OP_DATA, 10, 0, 0, OPC_TEXT, 1'b1, 1'b1);
        add_chunk(OP_DATA, 0, 0, 5, OPC_TEXT, 1'b1, 1'b1);
        add_chunk(OP_DATA, 131071, 0, 1, OPC_TEXT, 1'b1, 1'b1);
        add_chunk(OP_DATA, 10, 11, 1, OPC_TEXT, 1'b1, 1'b1);
        add_chunk(OP_DATA, 10, 4, 7, OPC_CONT, 1'b1, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, OPC_CLOSE, 1'b1, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, OPC_PING, 1'b1, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, OPC_PONG, 1'b1, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, 4'hF, 1'b0, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, OPC_CONT, 1'b0, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, OPC_TEXT, 1'b0, 1'b0);
        add_chunk(OP_DATA, 1, 0, 1, OPC_TEXT, 1'b1, 1'b1);
        add_chunk(OP_DATA, 65536, 0, 65536, OPC_TEXT, 1'b1, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, OPC_BINARY, 1'b0, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, OPC_TEXT, 1'b0, 1'b1);
        add_chunk(OP_DATA, 10, 4, 6, OPC_CONT, 1'b1, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, OPC_TEXT, 1'b0, 1'b1);
        add_chunk(OP_DATA, 10, 5, 5, OPC_CONT, 1'b1, 1'b1);
        add_chunk(OP_DATA, 10, 3, 2, OPC_CONT, 1'b0, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, OPC_TEXT, 1'b1, 1'b1);
        add_chunk(OP_DATA, 5, 0, 5, OPC_TEXT, 1'b0, 1'b1);
        add_chunk(OP_RESET, 5, 0, 5, OPC_TEXT, 1'b0, 1'b1);
        add_chunk(OP_DATA, 65536, 65535, 1, OPC_CONT, 1'b0, 1'b1);
        add_chunk(OP_DATA, 10, 0, 4, OPC_TEXT, 1'b0, 1'b1);
        add_chunk(OP_DATA, 10, 4, 2, 4'h3, 1'b0, 1'b1);
        directed_count = pending_chunks.size();

        while (pending_chunks.size() < directed_count + RANDOM_CHUNKS)
        begin
            if ($urandom_range(0, 99) < 70)
                add_message();
            else
                add_noise();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chunks.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d chunk transfers, %0d results, %0d text messages completed",
                 chunks_sent, results_seen, messages_done);
        $display("summary: status counts partial=%0d complete=%0d seq=%0d early_fin=%0d, %0d mismatches",
                 status_hits[ST_PARTIAL], status_hits[ST_COMPLETE], status_hits[ST_SEQUENCE],
                 status_hits[ST_EARLY_FIN], errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
